// ===== rtl/deadzone_run_length_encoder_defines.svh =====
// Assertion macros shared by the front, queue and back RTL files.
`ifndef DEADZONE_RUN_LENGTH_ENCODER_DEFINES_SVH
`define DEADZONE_RUN_LENGTH_ENCODER_DEFINES_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define DRLENC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define DRLENC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define DRLENC_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define DRLENC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/drlenc_pkg.sv =====
// Types and constants for the deadzone run-length encoder.
`timescale 1ns / 1ps
package drlenc_pkg;

   localparam int unsigned DATA_W = 16;
   localparam logic [DATA_W-1:0] RUN_MAX = 16'hFFFF;

   // Configuration register indexes
   localparam logic CSR_ZERO_THRESHOLD = 1'b0;
   localparam logic CSR_DEADZONE       = 1'b1;

   typedef struct packed {
      logic [DATA_W-1:0] sample;
      logic              frame_end;
   } drlenc_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] run_value;
      logic [DATA_W-1:0] run_length;
      logic              last_run;
   } drlenc_rsp_type;

   // One queue entry: the pairs that one item produces
   typedef struct packed {
      logic              brk_valid;
      logic [DATA_W-1:0] brk_value;
      logic [DATA_W-1:0] brk_length;
      logic              fin_valid;
      logic [DATA_W-1:0] fin_value;
      logic [DATA_W-1:0] fin_length;
   } drlenc_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } drlenc_qstat_type;

endpackage

// ===== rtl/drlenc_front.sv =====
// Front part: config registers, sample clamp, run tracking and pair generation.
`timescale 1ns / 1ps
`include "deadzone_run_length_encoder_defines.svh"
module drlenc_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  drlenc_pkg::drlenc_req_type  req_data,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [15:0]                 csr_wdata,
   input  drlenc_pkg::drlenc_qstat_type q_stat,
   output logic                        push,
   output drlenc_pkg::drlenc_entry_type push_entry
);
   import drlenc_pkg::*;

   logic [DATA_W-1:0] zero_threshold_ff, zero_threshold_in;
   logic [DATA_W-1:0] window_ff, window_in;
   logic [DATA_W-1:0] ref_value_ff, ref_value_in;
   logic [DATA_W-1:0] run_count_ff, run_count_in;
   logic              run_open_ff, run_open_in;

   logic              accept;
   logic              flush;
   logic [DATA_W-1:0] value;
   logic [DATA_W-1:0] delta;
   logic              in_window;
   logic [DATA_W-1:0] cur_value;
   logic [DATA_W-1:0] cur_count;

   // Hold input while the queue has no room
   assign req_stall = q_stat.full;
   assign accept    = req_valid && !req_stall;
   assign flush     = accept && req_data.frame_end;

   // Write configuration registers
   always_comb begin
      zero_threshold_in = zero_threshold_ff;
      window_in         = window_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ZERO_THRESHOLD: zero_threshold_in = csr_wdata;
            CSR_DEADZONE:       window_in         = csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp small samples to zero and measure distance from the run value
   assign value     = (req_data.sample < zero_threshold_ff) ? '0 : req_data.sample;
   assign delta     = (value >= ref_value_ff) ? (value - ref_value_ff)
                                              : (ref_value_ff - value);
   assign in_window = (delta <= window_ff);

   // Extend or break the run, then flush on frame end
   always_comb begin
      push_entry = '0;
      cur_value  = ref_value_ff;
      cur_count  = run_count_ff;
      if (run_open_ff) begin
         if (in_window && (run_count_ff != RUN_MAX)) begin
            cur_count = run_count_ff + 1'b1;
         end else begin
            push_entry.brk_valid  = 1'b1;
            push_entry.brk_value  = ref_value_ff;
            push_entry.brk_length = run_count_ff;
            cur_value = value;
            cur_count = DATA_W'(1);
         end
      end else begin
         cur_value = value;
         cur_count = DATA_W'(1);
      end
      push_entry.fin_valid  = req_data.frame_end;
      push_entry.fin_value  = cur_value;
      push_entry.fin_length = cur_count;
   end

   assign push = accept && (push_entry.brk_valid || push_entry.fin_valid);

   // Advance run state on accepted items
   always_comb begin
      ref_value_in = ref_value_ff;
      run_count_in = run_count_ff;
      run_open_in  = run_open_ff;
      if (accept) begin
         if (req_data.frame_end) begin
            ref_value_in = '0;
            run_count_in = '0;
            run_open_in  = 1'b0;
         end else begin
            ref_value_in = cur_value;
            run_count_in = cur_count;
            run_open_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_threshold_ff <= '0;
         window_ff         <= '0;
         ref_value_ff      <= '0;
         run_count_ff      <= '0;
         run_open_ff       <= 1'b0;
      end else begin
         zero_threshold_ff <= zero_threshold_in;
         window_ff         <= window_in;
         ref_value_ff      <= ref_value_in;
         run_count_ff      <= run_count_in;
         run_open_ff       <= run_open_in;
      end
   end

   `DRLENC_ASSERT_SAME(a_open_count, clock, reset, run_open_ff, run_count_ff != '0, "empty open run")
   `DRLENC_ASSERT_NEXT(a_frame_closes, clock, reset, flush, !run_open_ff, "run left open")

endmodule

// ===== rtl/drlenc_queue.sv =====
// Short entry queue between the front and back parts.
`timescale 1ns / 1ps
`include "deadzone_run_length_encoder_defines.svh"
module drlenc_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  drlenc_pkg::drlenc_entry_type push_entry,
   input  logic                         pop,
   output drlenc_pkg::drlenc_entry_type head_entry,
   output drlenc_pkg::drlenc_qstat_type q_stat
);
   import drlenc_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   drlenc_entry_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign q_stat.full  = (count_ff == FULL_CNT);
   assign q_stat.empty = (count_ff == '0);
   assign head_entry   = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap and track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `DRLENC_ASSERT_SAME(a_no_overflow, clock, reset, push, !q_stat.full, "push into full queue")
   `DRLENC_ASSERT_SAME(a_no_underflow, clock, reset, pop, !q_stat.empty, "pop from empty queue")

endmodule

// ===== rtl/drlenc_back.sv =====
// Back part: splits queue entries into pairs and drives the result register.
`timescale 1ns / 1ps
`include "deadzone_run_length_encoder_defines.svh"
module drlenc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  drlenc_pkg::drlenc_entry_type head_entry,
   input  drlenc_pkg::drlenc_qstat_type q_stat,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output drlenc_pkg::drlenc_rsp_type   rsp_data
);
   import drlenc_pkg::*;

   logic           rsp_valid_ff, rsp_valid_in;
   drlenc_rsp_type rsp_data_ff, rsp_data_in;
   logic           phase_ff, phase_in;
   logic           load;
   logic           send_brk;

   // Load the result register from a non-empty queue when it is empty or being taken
   assign load     = !q_stat.empty && (!rsp_valid_ff || !rsp_stall);
   assign send_brk = head_entry.brk_valid && !phase_ff;

   // Pick the break pair first, then the frame-end pair
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      phase_in     = phase_ff;
      pop          = 1'b0;
      if (load) begin
         rsp_valid_in = 1'b1;
         if (send_brk) begin
            rsp_data_in.run_value  = head_entry.brk_value;
            rsp_data_in.run_length = head_entry.brk_length;
            rsp_data_in.last_run   = 1'b0;
            phase_in = head_entry.fin_valid;
            pop      = !head_entry.fin_valid;
         end else begin
            rsp_data_in.run_value  = head_entry.fin_value;
            rsp_data_in.run_length = head_entry.fin_length;
            rsp_data_in.last_run   = 1'b1;
            phase_in = 1'b0;
            pop      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `DRLENC_ASSERT_SAME(a_phase_head, clock, reset, phase_ff, !q_stat.empty && head_entry.brk_valid && head_entry.fin_valid, "split phase without two-pair head")

endmodule

// ===== rtl/deadzone_run_length_encoder.sv =====
// Deadzone run-length encoder: top level joining front, queue and back parts.
//
// Usage: samples enter on the req_ channel (valid/stall), one item per cycle
// at most; each item carries one 16-bit sample and a frame_end flag. Finished
// runs leave on the rsp_ channel as value/length pairs with last_run set on
// the pair that closes a frame. Write zero_threshold (index 0) and the
// deadzone width (index 1) through csr_we/csr_index/csr_wdata while idle.
// Path: a pair caused by an accepted item is written into the queue, then
// loaded into the result register, from which it is presented on rsp_.
// Throughput: one item per cycle while the queue has room; the front
// classifies each item combinationally and pushes its pairs as a single
// queue entry. The back moves one pair per cycle unless the receiver stalls,
// so a break with frame end yields two pairs; QUEUE_DEPTH entries absorb this.
// Reset: both registers read 0, no run is open and the queue is empty.
// When the receiver stalls, the result register holds its pair, the queue
// fills, and req_stall rises once the queue is full.
`timescale 1ns / 1ps
module deadzone_run_length_encoder #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  drlenc_pkg::drlenc_req_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output drlenc_pkg::drlenc_rsp_type rsp_data,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [15:0]                csr_wdata
);
   import drlenc_pkg::*;

   logic             push;
   logic             pop;
   drlenc_entry_type push_entry;
   drlenc_entry_type head_entry;
   drlenc_qstat_type q_stat;

   drlenc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_stat     (q_stat),
      .push       (push),
      .push_entry (push_entry)
   );

   drlenc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_stat     (q_stat)
   );

   drlenc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .q_stat     (q_stat),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== test/deadzone_run_length_encoder_checker.sv =====
// Run-pair checker for the deadzone run-length encoder: predicts pairs and compares them.
`timescale 1ns / 1ps
module deadzone_run_length_encoder_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  drlenc_pkg::drlenc_req_type req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  drlenc_pkg::drlenc_rsp_type rsp_data,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [15:0]                csr_wdata,
   output int                         mismatch_count,
   output int                         outstanding
);
   import drlenc_pkg::*;

   // Shadow registers and the open run
   logic [15:0] zero_thresh;
   logic [15:0] deadzone;
   logic [15:0] run_ref;
   logic [15:0] run_len;
   logic        run_active;

   drlenc_rsp_type expected_runs[$];

   initial mismatch_count = 0;
   initial outstanding = 0;

   // Queue one finished run
   function automatic void close_run(input logic last);
      drlenc_rsp_type pair;
      pair.run_value  = run_ref;
      pair.run_length = run_len;
      pair.last_run   = last;
      expected_runs   = {expected_runs, pair};
   endfunction

   // Advance the run state by one sample and queue the pairs it finishes
   function automatic void encode_sample(input drlenc_req_type item);
      logic [15:0] clamped;
      int          ref_i, dz_i, val_i;
      logic        in_window;
      clamped = (item.sample < zero_thresh) ? 16'd0 : item.sample;
      if (run_active) begin
         ref_i = run_ref;
         dz_i  = deadzone;
         val_i = clamped;
         // compare in 32-bit signed so the window never wraps
         in_window = (val_i >= ref_i - dz_i) && (val_i <= ref_i + dz_i);
         if (in_window && run_len != RUN_MAX) begin
            run_len = run_len + 16'd1;
         end else begin
            close_run(1'b0);
            run_ref = clamped;
            run_len = 16'd1;
         end
      end else begin
         run_ref    = clamped;
         run_len    = 16'd1;
         run_active = 1'b1;
      end
      // frame end flushes the open run
      if (item.frame_end) begin
         close_run(1'b1);
         run_ref    = '0;
         run_len    = '0;
         run_active = 1'b0;
      end
   endfunction

   always @(posedge clock) begin
      drlenc_rsp_type want;
      if (reset) begin
         zero_thresh = '0;
         deadzone    = '0;
         run_ref     = '0;
         run_len     = '0;
         run_active  = 1'b0;
         expected_runs.delete();
      end else begin
         if (req_valid && !req_stall) begin
            encode_sample(req_data);
         end
         // compare each accepted pair against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_runs.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected pair, expected none, actual value %h length %0d last %0b",
                        $realtime, rsp_data.run_value, rsp_data.run_length, rsp_data.last_run);
            end else begin
               want = expected_runs.pop_front();
               if (rsp_data.run_value !== want.run_value) begin
                  mismatch_count++;
                  $display("%0t: run_value mismatch, expected %h actual %h",
                           $realtime, want.run_value, rsp_data.run_value);
               end
               if (rsp_data.run_length !== want.run_length) begin
                  mismatch_count++;
                  $display("%0t: run_length mismatch, expected %0d actual %0d",
                           $realtime, want.run_length, rsp_data.run_length);
               end
               if (rsp_data.last_run !== want.last_run) begin
                  mismatch_count++;
                  $display("%0t: last_run mismatch, expected %0b actual %0b",
                           $realtime, want.last_run, rsp_data.last_run);
               end
            end
         end
         // register writes apply from the next sample on
         if (csr_we) begin
            if (csr_index == CSR_ZERO_THRESHOLD) begin
               zero_thresh = csr_wdata;
            end else if (csr_index == CSR_DEADZONE) begin
               deadzone = csr_wdata;
            end
         end
      end
      outstanding <= expected_runs.size();
   end

endmodule

// ===== test/deadzone_run_length_encoder_tb.sv =====
// Stimulus, clocking and verdict for the deadzone run-length encoder testbench.
`timescale 1ns / 1ps
module deadzone_run_length_encoder_tb;
   import drlenc_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int FRAME_ITEMS   = 150;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_stall;
   drlenc_req_type req_data = '0;
   logic           rsp_valid;
   logic           rsp_stall = 1'b0;
   drlenc_rsp_type rsp_data;
   logic           csr_we = 1'b0;
   logic           csr_index = CSR_ZERO_THRESHOLD;
   logic [15:0]    csr_wdata = '0;

   int             mismatch_count;
   int             outstanding;
   int             cycle_count = 0;
   int             idle_pct = 8;
   int             stall_pct = 8;
   logic           hold_request = 1'b0;
   logic           hold_taken = 1'b0;
   int             hold_left = 0;

   // Stimulus copies of the registers, used to shape samples
   logic [15:0]    thresh_now = '0;
   logic [15:0]    dz_now = '0;
   logic [15:0]    run_base = '0;

   deadzone_run_length_encoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   deadzone_run_length_encoder_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Offer one item and hold it until accepted
   task automatic send_sample(input logic [15:0] sample, input logic frame_end);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{sample: sample, frame_end: frame_end};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid and wait until every predicted pair has come out
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] thresh, input logic [15:0] dz);
      write_csr(CSR_ZERO_THRESHOLD, thresh);
      write_csr(CSR_DEADZONE, dz);
      thresh_now = thresh;
      dz_now     = dz;
   endtask

   // Mostly samples near a drifting base so runs form; some wide and some low noise
   function automatic logic [15:0] next_sample();
      int pick, span, jitter;
      if ($urandom_range(99) < 15) run_base = 16'($urandom);
      span   = (dz_now > 30000) ? 30000 : dz_now + 2;
      jitter = $urandom_range(0, 2 * span);
      pick   = $urandom_range(99);
      if (pick < 70) return run_base + 16'(jitter - span);
      if (pick < 85) return 16'($urandom);
      return 16'($urandom_range(0, thresh_now));
   endfunction

   // Send frames of random length, each one closed by frame_end
   task automatic send_frames(input int count);
      int left, frame_len;
      left = count;
      while (left > 0) begin
         frame_len = $urandom_range(1, 20);
         if (frame_len > left) frame_len = left;
         for (int k = 0; k < frame_len; k++) begin
            send_sample(next_sample(), k == frame_len - 1);
         end
         left -= frame_len;
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Exact-match runs: single-sample frame, equal runs, break together with end
      set_config(16'd0, 16'd0);
      send_sample(16'hFFFF, 1'b1);
      send_sample(16'h0000, 1'b0);
      send_sample(16'h0000, 1'b0);
      send_sample(16'h0001, 1'b0);
      send_sample(16'h0001, 1'b1);
      send_sample(16'h0005, 1'b0);
      send_sample(16'h0007, 1'b1);
      send_sample(16'h0000, 1'b0);
      send_sample(16'hFFFF, 1'b1);
      drain();

      // Zero clamp and window edges
      set_config(16'd100, 16'd10);
      send_sample(16'd50, 1'b0);
      send_sample(16'd99, 1'b0);
      send_sample(16'd100, 1'b0);
      send_sample(16'd110, 1'b0);
      send_sample(16'd90, 1'b0);
      send_sample(16'd111, 1'b0);
      send_sample(16'd89, 1'b1);
      drain();

      // Widest window at both ends of the range, no wrap
      set_config(16'hFFFF, 16'hFFFF);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h1234, 1'b0);
      send_sample(16'h0000, 1'b0);
      send_sample(16'hFFFF, 1'b1);
      drain();

      // Random frames over several settings
      for (int s = 0; s < 6; s++) begin
         case (s)
            0: set_config(16'd0, 16'd0);
            1: set_config(16'hFFFF, 16'hFFFF);
            2: begin
               set_config(16'd0, 16'hFFFF);
               idle_pct  <= 0;
               stall_pct <= 0;
            end
            3: begin
               set_config(16'hFFFF, 16'd0);
               idle_pct  <= 8;
               stall_pct <= 8;
            end
            4: begin
               set_config(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 64)));
               // receiver holds off while items keep coming
               hold_request <= 1'b1;
            end
            default: set_config(16'($urandom), 16'($urandom));
         endcase
         send_frames(FRAME_ITEMS);
         drain();
      end

      if (mismatch_count == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/drlenc_pkg.sv
rtl/drlenc_front.sv
rtl/drlenc_queue.sv
rtl/drlenc_back.sv
rtl/deadzone_run_length_encoder.sv
test/deadzone_run_length_encoder_checker.sv
test/deadzone_run_length_encoder_tb.sv
